// ===== design/dfb_pkg.sv =====
`default_nettype none

package dfb_pkg;

  // Default geometry of the handle ring and the mark store.
  localparam int unsigned QueueDepthDef = 4096;
  localparam int unsigned MarkSlotsDef  = 1024;

  // Widths fixed by the stream formats.
  localparam int unsigned CmdW      = 3;
  localparam int unsigned HandleW   = 16;
  localparam int unsigned SlotW     = 11;
  localparam int unsigned OccW      = 13;
  localparam int unsigned CntW      = 32;
  localparam int unsigned BatchW    = 7;
  localparam int unsigned InDataW   = 32;
  localparam int unsigned OutDataW  = 160;

  // Largest batch one pop may emit, and the reset value of the batch register.
  localparam logic [BatchW-1:0] BatchCap = 7'd64;

  typedef enum logic [CmdW-1:0] {
    CmdPush     = 3'd0,
    CmdPop      = 3'd1,
    CmdDone     = 3'd2,
    CmdRstQueue = 3'd3,
    CmdRstStats = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    StsAccepted  = 3'd0,
    StsDuplicate = 3'd1,
    StsFull      = 3'd2,
    StsInvalid   = 3'd3,
    StsPopped    = 3'd4,
    StsEmpty     = 3'd5,
    StsDone      = 3'd6
  } status_e;

endpackage

`default_nettype wire

// ===== design/dedup_fifo_with_batch_pop.sv =====
`default_nettype none

// A push, done or reset result passes through the command register and then the output
// register; the first handle of a batch pop also waits for the ring read. No new item
// is taken until the current one is finished, and output stalls hold it longer.
// Reset: rst_ni clears pointers and counters and sets the batch register to 64, then a
// clearing pass writes every mark entry with s_axis_tready low; a reset-queue
// command starts the same clearing pass after its result is issued.
module dedup_fifo_with_batch_pop
  import dfb_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef,
  parameter int unsigned MARK_SLOTS  = MarkSlotsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,

  // Configuration: max_batch register.
  input  wire logic                cfg_we_i,
  input  wire logic [BatchW-1:0]   cfg_wdata_i,

  // Input stream.
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // From bit 0: handle[15:0], slot[26:16] (signed), zero fill [31:27].
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // cmd[2:0].
  input  wire logic [CmdW-1:0]     s_axis_tuser,

  // Result stream.
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // From bit 0: out_handle[15:0], occupancy[28:16], accepted_count[60:29],
  // duplicate_count[92:61], invalid_count[124:93], full_count[156:125], zero [159:157].
  output logic [OutDataW-1:0]      m_axis_tdata,
  // status[2:0].
  output logic [2:0]               m_axis_tuser,
  output logic                     m_axis_tlast
);

  localparam int unsigned PtrW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CountW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned MarkW = (MARK_SLOTS > 1) ? $clog2(MARK_SLOTS) : 1;

  typedef enum logic [1:0] {
    StClear,
    StIdle,
    StExec,
    StPop
  } state_e;

  // Ring pointer advance with wrap at the queue depth.
  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // A slot is usable when it is non-negative and below the number of marks.
  function automatic logic slot_valid(input logic [SlotW-1:0] s);
    return !s[SlotW-1] && ({22'd0, s[SlotW-2:0]} < 32'(MARK_SLOTS));
  endfunction

  function automatic logic [MarkW-1:0] slot_addr(input logic [SlotW-1:0] s);
    return MarkW'({22'd0, s[SlotW-2:0]});
  endfunction

  state_e               state_q, state_d;
  logic [BatchW-1:0]    max_batch_q, max_batch_d;
  logic [PtrW-1:0]      head_q, head_d, tail_q, tail_d;
  logic [CountW-1:0]    count_q, count_d;
  logic [CntW-1:0]      acc_cnt_q, acc_cnt_d, dup_cnt_q, dup_cnt_d;
  logic [CntW-1:0]      inv_cnt_q, inv_cnt_d, full_cnt_q, full_cnt_d;
  logic [MarkW-1:0]     clr_idx_q, clr_idx_d;
  logic [BatchW-1:0]    left_q, left_d;

  // The item under work.
  logic [CmdW-1:0]      cmd_q, cmd_d;
  logic [HandleW-1:0]   handle_q, handle_d;
  logic [SlotW-1:0]     slot_q, slot_d;

  // Output register.
  logic                 out_valid_q, out_valid_d;
  status_e              out_status_q, out_status_d;
  logic [HandleW-1:0]   out_handle_q, out_handle_d;
  logic                 out_last_q, out_last_d;
  logic [OccW-1:0]      out_occ_q, out_occ_d;
  logic [CntW-1:0]      out_acc_q, out_acc_d, out_dup_q, out_dup_d;
  logic [CntW-1:0]      out_inv_q, out_inv_d, out_full_q, out_full_d;

  // Memory ports.
  logic                 mark_we, mark_wdata, mark_re, mark_rdata;
  logic [MarkW-1:0]     mark_waddr, mark_raddr;
  logic                 ring_we, ring_re;
  logic [PtrW-1:0]      ring_waddr, ring_raddr;
  logic [HandleW-1:0]   ring_wdata, ring_rdata;

  logic                 can_load, load, ld_last, item_slot_ok;
  status_e              ld_status;
  logic [HandleW-1:0]   ld_handle;
  logic [BatchW-1:0]    limit, batch_n;

  dfb_ram #(
    .Width(1),
    .Depth(MARK_SLOTS)
  ) u_mark_ram (
    .clk_i   (clk_i),
    .we_i    (mark_we),
    .waddr_i (mark_waddr),
    .wdata_i (mark_wdata),
    .re_i    (mark_re),
    .raddr_i (mark_raddr),
    .rdata_o (mark_rdata)
  );

  dfb_ram #(
    .Width(HandleW),
    .Depth(QUEUE_DEPTH)
  ) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (ring_wdata),
    .re_i    (ring_re),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  // Items enter only while idle; the output register decouples the result side.
  assign s_axis_tready = (state_q == StIdle);
  assign can_load      = !out_valid_q || m_axis_tready;
  assign item_slot_ok  = slot_valid(slot_q);

  // A batch register of zero acts as one, anything above the cap as the cap.
  always_comb begin
    if (max_batch_q == '0) begin
      limit = BatchW'(1);
    end else if (max_batch_q > BatchCap) begin
      limit = BatchCap;
    end else begin
      limit = max_batch_q;
    end
    if (32'(count_q) < 32'(limit)) begin
      batch_n = BatchW'(count_q);
    end else begin
      batch_n = limit;
    end
  end

  always_comb begin
    state_d      = state_q;
    max_batch_d  = cfg_we_i ? cfg_wdata_i : max_batch_q;
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    acc_cnt_d    = acc_cnt_q;
    dup_cnt_d    = dup_cnt_q;
    inv_cnt_d    = inv_cnt_q;
    full_cnt_d   = full_cnt_q;
    clr_idx_d    = clr_idx_q;
    left_d       = left_q;
    cmd_d        = cmd_q;
    handle_d     = handle_q;
    slot_d       = slot_q;

    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_handle_d = out_handle_q;
    out_last_d   = out_last_q;
    out_occ_d    = out_occ_q;
    out_acc_d    = out_acc_q;
    out_dup_d    = out_dup_q;
    out_inv_d    = out_inv_q;
    out_full_d   = out_full_q;

    mark_we      = 1'b0;
    mark_waddr   = clr_idx_q;
    mark_wdata   = 1'b0;
    mark_re      = 1'b0;
    mark_raddr   = slot_addr(s_axis_tdata[26:16]);
    ring_we      = 1'b0;
    ring_waddr   = tail_q;
    ring_wdata   = handle_q;
    ring_re      = 1'b0;
    ring_raddr   = head_q;

    load         = 1'b0;
    ld_status    = StsDone;
    ld_handle    = '0;
    ld_last      = 1'b1;

    case (state_q)
      StClear: begin
        // One mark entry cleared per cycle.
        mark_we = 1'b1;
        if (clr_idx_q == MarkW'(MARK_SLOTS - 1)) begin
          clr_idx_d = '0;
          state_d   = StIdle;
        end else begin
          clr_idx_d = clr_idx_q + 1'b1;
        end
      end

      StIdle: begin
        if (s_axis_tvalid) begin
          cmd_d    = s_axis_tuser;
          handle_d = s_axis_tdata[15:0];
          slot_d   = s_axis_tdata[26:16];
          // The mark read is started right away so a push can decide in the execute state.
          mark_re  = 1'b1;
          if (s_axis_tuser inside {[CmdPush:CmdRstStats]}) begin
            state_d = StExec;
          end
        end
      end

      StExec: begin
        if (can_load) begin
          case (cmd_q)
            CmdPush: begin
              load    = 1'b1;
              state_d = StIdle;
              if (!item_slot_ok) begin
                inv_cnt_d = inv_cnt_q + 1'b1;
                ld_status = StsInvalid;
              end else if (mark_rdata) begin
                dup_cnt_d = dup_cnt_q + 1'b1;
                ld_status = StsDuplicate;
              end else if (count_q == CountW'(QUEUE_DEPTH)) begin
                full_cnt_d = full_cnt_q + 1'b1;
                ld_status  = StsFull;
              end else begin
                ring_we    = 1'b1;
                tail_d     = ptr_inc(tail_q);
                count_d    = count_q + 1'b1;
                mark_we    = 1'b1;
                mark_waddr = slot_addr(slot_q);
                mark_wdata = 1'b1;
                acc_cnt_d  = acc_cnt_q + 1'b1;
                ld_status  = StsAccepted;
              end
            end
            CmdPop: begin
              if (count_q == '0) begin
                load      = 1'b1;
                ld_status = StsEmpty;
                state_d   = StIdle;
              end else begin
                // First ring read; the handle is loaded in the pop state.
                ring_re = 1'b1;
                head_d  = ptr_inc(head_q);
                left_d  = batch_n - 1'b1;
                state_d = StPop;
              end
            end
            CmdDone: begin
              load    = 1'b1;
              state_d = StIdle;
              if (item_slot_ok) begin
                mark_we    = 1'b1;
                mark_waddr = slot_addr(slot_q);
                mark_wdata = 1'b0;
              end
            end
            CmdRstQueue: begin
              load      = 1'b1;
              head_d    = '0;
              tail_d    = '0;
              count_d   = '0;
              clr_idx_d = '0;
              state_d   = StClear;
            end
            CmdRstStats: begin
              load       = 1'b1;
              acc_cnt_d  = '0;
              dup_cnt_d  = '0;
              inv_cnt_d  = '0;
              full_cnt_d = '0;
              state_d    = StIdle;
            end
            default: begin
              state_d = StIdle;
            end
          endcase
        end
      end

      StPop: begin
        // The ring data holds while the output stalls, since no new read is issued.
        if (can_load) begin
          load      = 1'b1;
          ld_status = StsPopped;
          ld_handle = ring_rdata;
          ld_last   = (left_q == '0);
          count_d   = count_q - 1'b1;
          if (left_q != '0) begin
            ring_re = 1'b1;
            head_d  = ptr_inc(head_q);
            left_d  = left_q - 1'b1;
          end else begin
            state_d = StIdle;
          end
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase

    // Every result reports the state as it stands after that result.
    if (load) begin
      out_valid_d  = 1'b1;
      out_status_d = ld_status;
      out_handle_d = ld_handle;
      out_last_d   = ld_last;
      out_occ_d    = OccW'(count_d);
      out_acc_d    = acc_cnt_d;
      out_dup_d    = dup_cnt_d;
      out_inv_d    = inv_cnt_d;
      out_full_d   = full_cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StClear;
      max_batch_q  <= BatchCap;
      head_q       <= '0;
      tail_q       <= '0;
      count_q      <= '0;
      acc_cnt_q    <= '0;
      dup_cnt_q    <= '0;
      inv_cnt_q    <= '0;
      full_cnt_q   <= '0;
      clr_idx_q    <= '0;
      left_q       <= '0;
      cmd_q        <= '0;
      handle_q     <= '0;
      slot_q       <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= StsDone;
      out_handle_q <= '0;
      out_last_q   <= 1'b0;
      out_occ_q    <= '0;
      out_acc_q    <= '0;
      out_dup_q    <= '0;
      out_inv_q    <= '0;
      out_full_q   <= '0;
    end else begin
      state_q      <= state_d;
      max_batch_q  <= max_batch_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      count_q      <= count_d;
      acc_cnt_q    <= acc_cnt_d;
      dup_cnt_q    <= dup_cnt_d;
      inv_cnt_q    <= inv_cnt_d;
      full_cnt_q   <= full_cnt_d;
      clr_idx_q    <= clr_idx_d;
      left_q       <= left_d;
      cmd_q        <= cmd_d;
      handle_q     <= handle_d;
      slot_q       <= slot_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_handle_q <= out_handle_d;
      out_last_q   <= out_last_d;
      out_occ_q    <= out_occ_d;
      out_acc_q    <= out_acc_d;
      out_dup_q    <= out_dup_d;
      out_inv_q    <= out_inv_d;
      out_full_q   <= out_full_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {3'd0, out_full_q, out_inv_q, out_dup_q, out_acc_q,
                          out_occ_q, out_handle_q};

endmodule

`default_nettype wire

// ===== design/dfb_ram.sv =====
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
// The read data holds its value until the next read.
module dfb_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 4096,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== tb/dedup_fifo_with_batch_pop_tb.sv =====
`default_nettype none

module dedup_fifo_with_batch_pop_tb;
  import dfb_pkg::*;

  // Geometry of the block under test, taken from the package defaults.
  localparam int unsigned RingDepth = QueueDepthDef;
  localparam int unsigned MarkSlots = MarkSlotsDef;

  // Command codes the block does not decode; it must drop them without a result.
  localparam logic [CmdW-1:0] CmdSpareLo = 3'd5;
  localparam logic [CmdW-1:0] CmdSpareHi = 3'd7;

  // Field positions inside the result tdata, lowest field first.
  localparam int unsigned OccLsb  = HandleW;
  localparam int unsigned AccLsb  = OccLsb + OccW;
  localparam int unsigned DupLsb  = AccLsb + CntW;
  localparam int unsigned InvLsb  = DupLsb + CntW;
  localparam int unsigned FullLsb = InvLsb + CntW;

  // The slowest legal run stays well below this: the reset and every queue reset start
  // a full mark clearing pass, and a pop of up to 64 handles can meet long
  // stretches of output stalls.
  localparam int unsigned CycleLimit  = 1000000;
  // Cycles left after the last result so that a late or extra result still shows up.
  localparam int unsigned SettleCycles = 16;

  typedef struct {
    status_e              sts;
    logic [HandleW-1:0]   hnd;
    logic                 lst;
    logic [OccW-1:0]      occ;
    logic [CntW-1:0]      acc;
    logic [CntW-1:0]      dup;
    logic [CntW-1:0]      inv;
    logic [CntW-1:0]      ful;
  } result_t;

  // One row of the directed stimulus. Where typed is set, the status of the first
  // result is the one written in the row; all other fields come from the predictor.
  typedef struct {
    logic [CmdW-1:0]    cmd;
    logic [HandleW-1:0] hnd;
    logic [SlotW-1:0]   slot;
    bit                 typed;
    status_e            sts;
  } op_row_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [BatchW-1:0]   cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  wire logic           s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [CmdW-1:0]     s_axis_tuser  = '0;
  wire logic           m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  wire logic [OutDataW-1:0] m_axis_tdata;
  wire logic [2:0]     m_axis_tuser;
  wire logic           m_axis_tlast;

  dedup_fifo_with_batch_pop dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the queue: handle ring, per-slot marks, pointers and statistics.
  logic [HandleW-1:0] ring_copy [RingDepth];
  bit                 slot_marked [MarkSlots];
  int unsigned        head_idx   = 0;
  int unsigned        tail_idx   = 0;
  int unsigned        fill_level = 0;
  logic [CntW-1:0]    n_acc = '0;
  logic [CntW-1:0]    n_dup = '0;
  logic [CntW-1:0]    n_inv = '0;
  logic [CntW-1:0]    n_full = '0;
  logic [BatchW-1:0]  batch_reg = BatchCap;

  // Results the block still owes, oldest first.
  result_t pending_results [$];

  int unsigned err_count      = 0;
  int unsigned ops_sent       = 0;
  int unsigned ignored_ops    = 0;
  int unsigned results_seen   = 0;
  int unsigned cycle_count    = 0;
  int unsigned status_seen [8];
  int          burst_left     = 0;
  int unsigned stall_tick     = 0;
  int unsigned stall_mode     = 0;

  // Batch sizes visited by the random phases, including zero (treated as one) and
  // values past the cap (which saturate).
  logic [BatchW-1:0] batch_plan [8] = '{7'd0, 7'd127, 7'd1, 7'd3, 7'd64, 7'd65, 7'd2,
                                        7'd100};

  // Directed opening: empty pop, handle and slot extremes, the duplicate and invalid
  // rejections, done on invalid and unmarked slots, the undecoded commands, both resets.
  op_row_t directed_rows [22] = '{
    '{CmdPop,      16'h0000, 11'h000, 1'b1, StsEmpty},
    '{CmdPush,     16'h0000, 11'h000, 1'b1, StsAccepted},
    '{CmdPush,     16'hFFFF, 11'h3FF, 1'b1, StsAccepted},
    '{CmdPush,     16'h1234, 11'h000, 1'b1, StsDuplicate},
    '{CmdPush,     16'h0F0F, 11'h7FF, 1'b1, StsInvalid},
    '{CmdPush,     16'hF0F0, 11'h400, 1'b1, StsInvalid},
    '{CmdDone,     16'h0000, 11'h000, 1'b1, StsDone},
    '{CmdPush,     16'hAAAA, 11'h000, 1'b1, StsAccepted},
    '{CmdDone,     16'hFFFF, 11'h7FF, 1'b1, StsDone},
    '{CmdDone,     16'h0000, 11'h005, 1'b1, StsDone},
    '{CmdSpareLo,  16'h5555, 11'h001, 1'b0, StsDone},
    '{CmdSpareHi,  16'hAAAA, 11'h7FE, 1'b0, StsDone},
    '{CmdPop,      16'h0000, 11'h000, 1'b0, StsDone},
    '{CmdPush,     16'h5555, 11'h002, 1'b1, StsAccepted},
    '{CmdRstStats, 16'h0000, 11'h000, 1'b1, StsDone},
    '{CmdPush,     16'h6666, 11'h002, 1'b1, StsDuplicate},
    '{CmdRstQueue, 16'h0000, 11'h000, 1'b1, StsDone},
    '{CmdPush,     16'h5A5A, 11'h002, 1'b1, StsAccepted},
    '{CmdPop,      16'h0000, 11'h000, 1'b0, StsDone},
    '{CmdSpareLo + 3'd1, 16'h3333, 11'h155, 1'b0, StsDone},
    '{CmdPush,     16'h3C3C, 11'h003, 1'b1, StsAccepted},
    '{CmdPop,      16'h0000, 11'h000, 1'b0, StsDone}
  };

  // Queue one expected result, stamped with the shadow state as it stands now.
  function automatic void post_result(status_e sts, logic [HandleW-1:0] hnd, logic lst);
    result_t r;
    r.sts = sts;
    r.hnd = hnd;
    r.lst = lst;
    r.occ = OccW'(fill_level);
    r.acc = n_acc;
    r.dup = n_dup;
    r.inv = n_inv;
    r.ful = n_full;
    pending_results.push_back(r);
  endfunction

  // Apply one accepted command to the shadow queue and queue the results it causes.
  function automatic void apply_queue_op(logic [CmdW-1:0] op, logic [HandleW-1:0] hnd,
                                         logic [SlotW-1:0] slot_raw);
    int          s;
    bit          slot_ok;
    int unsigned lim;
    int unsigned n;
    s = int'($signed(slot_raw));
    slot_ok = (s >= 0) && (s < int'(MarkSlots));
    case (op)
      CmdPush: begin
        // Rejection order matters: invalid before duplicate before full.
        if (!slot_ok) begin
          n_inv++;
          post_result(StsInvalid, '0, 1'b1);
        end else if (slot_marked[s]) begin
          n_dup++;
          post_result(StsDuplicate, '0, 1'b1);
        end else if (fill_level >= RingDepth) begin
          n_full++;
          post_result(StsFull, '0, 1'b1);
        end else begin
          ring_copy[tail_idx] = hnd;
          tail_idx = (tail_idx + 1) % RingDepth;
          fill_level++;
          slot_marked[s] = 1'b1;
          n_acc++;
          post_result(StsAccepted, '0, 1'b1);
        end
      end
      CmdPop: begin
        lim = 32'(batch_reg);
        if (lim == 0) lim = 1;
        if (lim > 32'(BatchCap)) lim = 32'(BatchCap);
        if (fill_level == 0) begin
          post_result(StsEmpty, '0, 1'b1);
        end else begin
          n = (fill_level < lim) ? fill_level : lim;
          for (int k = 0; k < int'(n); k++) begin
            logic [HandleW-1:0] v;
            v = ring_copy[head_idx];
            head_idx = (head_idx + 1) % RingDepth;
            fill_level--;
            post_result(StsPopped, v, k == int'(n) - 1);
          end
        end
      end
      CmdDone: begin
        if (slot_ok) slot_marked[s] = 1'b0;
        post_result(StsDone, '0, 1'b1);
      end
      CmdRstQueue: begin
        // The ring contents survive; only marks, pointers and the count go.
        foreach (slot_marked[i]) slot_marked[i] = 1'b0;
        head_idx = 0;
        tail_idx = 0;
        fill_level = 0;
        post_result(StsDone, '0, 1'b1);
      end
      CmdRstStats: begin
        n_acc = '0;
        n_dup = '0;
        n_inv = '0;
        n_full = '0;
        post_result(StsDone, '0, 1'b1);
      end
      default: begin
        // Undecoded command: no result and no change.
      end
    endcase
  endfunction

  // Offer one command and hold it until the block takes the transfer. The sender runs
  // in bursts: while burst_left is positive the next command follows back to back,
  // otherwise tvalid drops for a random gap and a new burst length is drawn.
  task automatic send_op(logic [CmdW-1:0] op, logic [HandleW-1:0] hnd,
                         logic [SlotW-1:0] slot_raw, bit typed, status_e want_sts);
    int unsigned first_idx;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataW - HandleW - SlotW){1'b0}}, slot_raw, hnd};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    first_idx = pending_results.size();
    apply_queue_op(op, hnd, slot_raw);
    if (typed && pending_results.size() > first_idx)
      pending_results[first_idx].sts = want_sts;
    if (op > CmdRstStats) ignored_ops++;
    else ops_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      // Now and then a long back-to-back stretch with no idling at all.
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 7);
    end
  endtask

  // Stop sending until every owed result has come back, then let the block settle.
  // This also covers undecoded commands, which leave nothing to wait for.
  task automatic pause_until_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write max_batch while the block is idle. A queue reset may still be running its
  // clearing pass, which shows as tready held low, so that is waited out too.
  task automatic write_batch_reg(logic [BatchW-1:0] value);
    pause_until_drained();
    while (!s_axis_tready) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    batch_reg = value;
    cfg_we_i  <= 1'b0;
  endtask

  task automatic check_field(string what, logic [CntW-1:0] want, logic [CntW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
      err_count++;
    end
  endtask

  // Result side: compare each transfer out with the oldest expectation, and pick the
  // next tready from a stall pattern redrawn at random: always ready, random, or periodic.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      status_seen[m_axis_tuser]++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual status %0d handle %h",
                 $time, m_axis_tuser, m_axis_tdata[HandleW-1:0]);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        check_field("status", CntW'(want.sts), CntW'(m_axis_tuser));
        check_field("out_handle", CntW'(want.hnd), CntW'(m_axis_tdata[HandleW-1:0]));
        check_field("last", CntW'(want.lst), CntW'(m_axis_tlast));
        check_field("occupancy", CntW'(want.occ), CntW'(m_axis_tdata[OccLsb +: OccW]));
        check_field("accepted_count", want.acc, m_axis_tdata[AccLsb +: CntW]);
        check_field("duplicate_count", want.dup, m_axis_tdata[DupLsb +: CntW]);
        check_field("invalid_count", want.inv, m_axis_tdata[InvLsb +: CntW]);
        check_field("full_count", want.ful, m_axis_tdata[FullLsb +: CntW]);
      end
    end
    stall_tick++;
    if (stall_tick % 97 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= (stall_tick % 4 == 0);
      default: m_axis_tready <= (stall_tick % 5 != 2);
    endcase
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Run stopped at cycle %0d with %0d results outstanding.", cycle_count,
               pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned pick;
    int unsigned phase_start;
    logic [SlotW-1:0] slot_raw;

    foreach (slot_marked[i]) slot_marked[i] = 1'b0;
    foreach (status_seen[i]) status_seen[i] = 0;

    // Reset once. The block then runs its mark clearing pass with tready low, which the
    // first transfer simply waits out.
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows, with max_batch at its reset value.
    foreach (directed_rows[i])
      send_op(directed_rows[i].cmd, directed_rows[i].hnd, directed_rows[i].slot,
              directed_rows[i].typed, directed_rows[i].sts);

    // Random phases, one per batch size. Most traffic is pushes and dones on a small
    // pool of slots so that duplicates and re-queued slots are common, with pops of
    // every size, some wide-range and negative slots, rare resets and some noise.
    foreach (batch_plan[p]) begin
      write_batch_reg(batch_plan[p]);
      phase_start = ops_sent;
      while (ops_sent - phase_start < 13) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          send_op(CmdPush, HandleW'($urandom), SlotW'($urandom_range(0, 15)), 1'b0,
                  StsDone);
        end else if (pick < 48) begin
          send_op(CmdPush, HandleW'($urandom), SlotW'($urandom_range(0, MarkSlots - 1)),
                  1'b0, StsDone);
        end else if (pick < 53) begin
          send_op(CmdPush, HandleW'($urandom), SlotW'($urandom_range(1024, 2047)), 1'b0,
                  StsDone);
        end else if (pick < 68) begin
          slot_raw = ($urandom_range(0, 7) == 0) ? SlotW'($urandom_range(1024, 2047))
                                                 : SlotW'($urandom_range(0, 15));
          send_op(CmdDone, HandleW'($urandom), slot_raw, 1'b0, StsDone);
        end else if (pick < 88) begin
          send_op(CmdPop, HandleW'($urandom), SlotW'($urandom), 1'b0, StsDone);
        end else if (pick < 91) begin
          send_op(CmdRstQueue, HandleW'($urandom), SlotW'($urandom), 1'b0, StsDone);
        end else if (pick < 94) begin
          send_op(CmdRstStats, HandleW'($urandom), SlotW'($urandom), 1'b0, StsDone);
        end else begin
          send_op(CmdW'($urandom_range(CmdSpareLo, CmdSpareHi)), HandleW'($urandom),
                  SlotW'($urandom), 1'b0, StsDone);
        end
      end
    end

    pause_until_drained();

    $display("Run moved %0d command transfers in (%0d undecoded) and checked %0d results.",
             ops_sent + ignored_ops, ignored_ops, results_seen);
    $display("Statuses seen: acc %0d dup %0d full %0d inv %0d pop %0d empty %0d done %0d.",
             status_seen[StsAccepted], status_seen[StsDuplicate], status_seen[StsFull],
             status_seen[StsInvalid], status_seen[StsPopped], status_seen[StsEmpty],
             status_seen[StsDone]);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
